// ===== sv/fmpf_pkg.sv =====
package fmpf_pkg;

  localparam int RULE_SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int STAT_COUNT = 7;

  localparam logic [2:0] ACT_CHECK = 3'd0;
  localparam logic [2:0] ACT_ADD = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_READ_COUNT = 3'd4;
  localparam logic [2:0] ACT_READ_STAT = 3'd5;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_DEF_IN = 3'd0;
  localparam logic [2:0] ADDR_DEF_OUT = 3'd4;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] RCLASS_TCP = 2'd1;
  localparam logic [1:0] RCLASS_UDP = 2'd2;
  localparam logic [1:0] RCLASS_ICMP = 2'd3;
  localparam logic [1:0] DIR_BOTH = 2'd2;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_DROP = 2'd1;
  localparam logic [1:0] VERDICT_REJECT = 2'd2;

  localparam logic [2:0] STAT_TOTAL_IN = 3'd0;
  localparam logic [2:0] STAT_TOTAL_OUT = 3'd1;
  localparam logic [2:0] STAT_ACC_IN = 3'd2;
  localparam logic [2:0] STAT_ACC_OUT = 3'd3;
  localparam logic [2:0] STAT_DROP_IN = 3'd4;
  localparam logic [2:0] STAT_DROP_OUT = 3'd5;
  localparam logic [2:0] STAT_REJECT = 3'd6;

  typedef struct packed {
    logic [1:0] direction;
    logic [7:0] ip_protocol;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } pkt_t;

  // command from the control block to every cell
  typedef struct packed {
    logic check;
    logic add;
    logic remove;
    logic flush;
    logic [SLOT_W-1:0] sel;
    logic [1:0] rdir;
    logic [1:0] rproto;
    logic [1:0] rverdict;
  } cell_cmd_t;

  // value carried along the chain, lowest slot first
  typedef struct packed {
    logic hit;
    logic free;
    logic [SLOT_W-1:0] hit_idx;
    logic [SLOT_W-1:0] free_idx;
    logic [1:0] verdict;
  } chain_t;

  function automatic logic [1:0] norm_verdict(input logic [1:0] v);
    return (v == 2'd3) ? VERDICT_REJECT : v;
  endfunction

endpackage

// ===== sv/fmpf_cell.sv =====
module fmpf_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [fmpf_pkg::SLOT_W-1:0] my_idx,
  input  fmpf_pkg::cell_cmd_t   cmd,
  input  fmpf_pkg::pkt_t        pkt,
  input  logic [31:0]           smask,
  input  logic [31:0]           dmask,
  input  logic                  take_add,
  input  logic                  take_hit,
  input  fmpf_pkg::chain_t      chain_in,
  output fmpf_pkg::chain_t      chain_out,
  output logic                  in_use,
  output logic [31:0]           count
);
  import fmpf_pkg::*;

  logic [1:0] rdir, rproto, rverdict;
  logic [31:0] rsrc, rdst, msrc, mdst;
  logic [15:0] rsport, rdport;
  logic hits, is_tu, ok_proto, ok_port;

  always_comb begin
    is_tu = (pkt.ip_protocol == PROTO_TCP) || (pkt.ip_protocol == PROTO_UDP);
    case (rproto)
      RCLASS_TCP: ok_proto = pkt.ip_protocol == PROTO_TCP;
      RCLASS_UDP: ok_proto = pkt.ip_protocol == PROTO_UDP;
      RCLASS_ICMP: ok_proto = pkt.ip_protocol == PROTO_ICMP;
      default: ok_proto = 1'b1;
    endcase
    ok_port = ((rsport == 16'd0) && (rdport == 16'd0)) ||
              (is_tu && (rsport == 16'd0 || rsport == pkt.sport) &&
               (rdport == 16'd0 || rdport == pkt.dport));
    hits = in_use && (rdir == DIR_BOTH || rdir == pkt.direction) && ok_proto &&
           (rsrc == 32'd0 || (pkt.src & msrc) == (rsrc & msrc)) &&
           (rdst == 32'd0 || (pkt.dst & mdst) == (rdst & mdst)) && ok_port;
    chain_out = chain_in;
    if (!chain_in.hit && hits) begin
      chain_out.hit = 1'b1;
      chain_out.hit_idx = my_idx;
      chain_out.verdict = norm_verdict(rverdict);
    end
    if (!chain_in.free && !in_use) begin
      chain_out.free = 1'b1;
      chain_out.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
      count <= 32'd0;
    end else if (cmd.flush) begin
      in_use <= 1'b0;
      count <= 32'd0;
    end else if (cmd.add && take_add) begin
      in_use <= 1'b1;
      count <= 32'd0;
    end else if (cmd.remove && cmd.sel == my_idx) begin
      in_use <= 1'b0;
    end else if (cmd.check && take_hit) begin
      count <= count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && take_add) begin
      rdir <= cmd.rdir;
      rproto <= cmd.rproto;
      rverdict <= cmd.rverdict;
      rsrc <= pkt.src;
      rdst <= pkt.dst;
      msrc <= smask;
      mdst <= dmask;
      rsport <= pkt.sport;
      rdport <= pkt.dport;
    end
  end

endmodule

// ===== sv/first_match_packet_filter.sv =====
// First-match packet filter. Each command (check, add, remove, flush, read
// counter) is taken when start is high and busy is low; busy stays low, so
// one command may be issued every clock. Its result appears one cycle later
// for one cycle with done high and must be taken then: there is no stall.
// The rules sit in a chain of 16 slot cells; the lowest matching and lowest
// free slots ripple through the chain within that cycle.
module first_match_packet_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [1:0]  direction,
  input  logic [7:0]  ip_protocol,
  input  logic [1:0]  rule_protocol,
  input  logic [1:0]  verdict_in,
  input  logic [31:0] source_address,
  input  logic [31:0] source_mask,
  input  logic [31:0] dest_address,
  input  logic [31:0] dest_mask,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [3:0]  slot,
  output logic        done,
  output logic [1:0]  verdict,
  output logic        matched,
  output logic [3:0]  rule_index,
  output logic        status,
  output logic [31:0] count_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fmpf_pkg::*;

  logic [1:0] def_in, def_out;
  logic [31:0] stats [STAT_COUNT];
  cell_cmd_t cmd;
  pkt_t pkt;
  chain_t chain [RULE_SLOTS+1];
  logic [RULE_SLOTS-1:0] use_v;
  logic [31:0] counts [RULE_SLOTS];
  logic go, inbound;
  logic [1:0] chk_verdict;
  logic [2:0] stat_sel;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign go = start;
  assign inbound = direction == 2'd0;

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      1'b0: prdata = {30'd0, def_in};
      default: prdata = {30'd0, def_out};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      def_in <= 2'd0;
      def_out <= 2'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_DEF_IN) def_in <= pwdata[1:0];
      else if (paddr == ADDR_DEF_OUT) def_out <= pwdata[1:0];
    end
  end

  assign pkt = '{direction: direction, ip_protocol: ip_protocol, src: source_address,
                 dst: dest_address, sport: source_port, dport: dest_port};
  assign cmd = '{check: go && action == ACT_CHECK, add: go && action == ACT_ADD,
                 remove: go && action == ACT_REMOVE, flush: go && action == ACT_FLUSH,
                 sel: slot, rdir: direction, rproto: rule_protocol,
                 rverdict: verdict_in};
  assign chain[0] = '0;

  for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
    fmpf_cell u_cell (
      .clk(clk), .rst(rst), .my_idx(SLOT_W'(g)), .cmd(cmd), .pkt(pkt),
      .smask(source_mask), .dmask(dest_mask),
      .take_add(!chain[g].free && !use_v[g]),
      .take_hit(chain[g+1].hit && !chain[g].hit),
      .chain_in(chain[g]), .chain_out(chain[g+1]),
      .in_use(use_v[g]), .count(counts[g])
    );
  end

  assign chk_verdict = chain[RULE_SLOTS].hit ? chain[RULE_SLOTS].verdict
                     : norm_verdict(inbound ? def_in : def_out);
  assign stat_sel = slot[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAT_COUNT; i++) stats[i] <= 32'd0;
    end else if (cmd.check) begin
      if (inbound) stats[STAT_TOTAL_IN] <= stats[STAT_TOTAL_IN] + 32'd1;
      else stats[STAT_TOTAL_OUT] <= stats[STAT_TOTAL_OUT] + 32'd1;
      case (chk_verdict)
        VERDICT_ACCEPT: begin
          if (inbound) stats[STAT_ACC_IN] <= stats[STAT_ACC_IN] + 32'd1;
          else stats[STAT_ACC_OUT] <= stats[STAT_ACC_OUT] + 32'd1;
        end
        VERDICT_DROP: begin
          if (inbound) stats[STAT_DROP_IN] <= stats[STAT_DROP_IN] + 32'd1;
          else stats[STAT_DROP_OUT] <= stats[STAT_DROP_OUT] + 32'd1;
        end
        default: stats[STAT_REJECT] <= stats[STAT_REJECT] + 32'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= go;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      verdict <= 2'd0;
      matched <= 1'b0;
      rule_index <= 4'd0;
      status <= 1'b0;
      count_value <= 32'd0;
      case (action)
        ACT_CHECK: begin
          verdict <= chk_verdict;
          matched <= chain[RULE_SLOTS].hit;
          rule_index <= chain[RULE_SLOTS].hit ? chain[RULE_SLOTS].hit_idx : 4'd0;
        end
        ACT_ADD: begin
          if (chain[RULE_SLOTS].free) rule_index <= chain[RULE_SLOTS].free_idx;
          else status <= 1'b1;
        end
        ACT_REMOVE: status <= !use_v[slot];
        ACT_FLUSH: status <= 1'b0;
        ACT_READ_COUNT: begin
          count_value <= counts[slot];
          status <= !use_v[slot];
        end
        ACT_READ_STAT: begin
          if (slot > 4'd6) status <= 1'b1;
          else count_value <= stats[stat_sel];
        end
        default: status <= 1'b1;
      endcase
    end
  end

endmodule

// ===== tb/first_match_packet_filter_tb.sv =====
`timescale 1ns / 1ps

module first_match_packet_filter_tb;
  import fmpf_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  direction;
    logic [7:0]  ip_protocol;
    logic [1:0]  rule_protocol;
    logic [1:0]  verdict_in;
    logic [31:0] source_address;
    logic [31:0] source_mask;
    logic [31:0] dest_address;
    logic [31:0] dest_mask;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  slot;
  } word_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        matched;
    logic [3:0]  rule_index;
    logic        status;
    logic [31:0] count_value;
  } outcome_t;

  logic clk, rst, start, busy, done;
  word_t drv;
  logic [1:0] verdict;
  logic matched, status, pready;
  logic [3:0] rule_index;
  logic [31:0] count_value, prdata;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;

  first_match_packet_filter DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(drv.action), .direction(drv.direction), .ip_protocol(drv.ip_protocol),
    .rule_protocol(drv.rule_protocol), .verdict_in(drv.verdict_in),
    .source_address(drv.source_address), .source_mask(drv.source_mask),
    .dest_address(drv.dest_address), .dest_mask(drv.dest_mask),
    .source_port(drv.source_port), .dest_port(drv.dest_port), .slot(drv.slot),
    .done(done), .verdict(verdict), .matched(matched), .rule_index(rule_index),
    .status(status), .count_value(count_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // filter state as the testbench sees it
  logic        rule_valid [RULE_SLOTS];
  logic [1:0]  rule_dir [RULE_SLOTS];
  logic [1:0]  rule_class [RULE_SLOTS];
  logic [1:0]  rule_verdict [RULE_SLOTS];
  logic [31:0] rule_src [RULE_SLOTS];
  logic [31:0] rule_dst [RULE_SLOTS];
  logic [31:0] rule_smask [RULE_SLOTS];
  logic [31:0] rule_dmask [RULE_SLOTS];
  logic [15:0] rule_sport [RULE_SLOTS];
  logic [15:0] rule_dport [RULE_SLOTS];
  logic [31:0] hit_count [RULE_SLOTS];
  logic [31:0] stats [STAT_COUNT];
  logic [1:0]  dflt_in, dflt_out;

  word_t    pending_words[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int gap_left = 0;
  bit no_gaps = 0;
  int quiet_cycles = 0;
  logic [31:0] addr_pool [4];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [1:0] fold_verdict(logic [1:0] v);
    return (v == 2'd3) ? VERDICT_REJECT : v;
  endfunction

  function automatic bit slot_accepts(int s, word_t w);
    bit l4;
    l4 = (w.ip_protocol == PROTO_TCP) || (w.ip_protocol == PROTO_UDP);
    if (rule_dir[s] != DIR_BOTH && rule_dir[s] != w.direction) return 0;
    if (rule_class[s] == RCLASS_TCP && w.ip_protocol != PROTO_TCP) return 0;
    if (rule_class[s] == RCLASS_UDP && w.ip_protocol != PROTO_UDP) return 0;
    if (rule_class[s] == RCLASS_ICMP && w.ip_protocol != PROTO_ICMP) return 0;
    if (rule_src[s] != 0 && (w.source_address & rule_smask[s]) != (rule_src[s] & rule_smask[s]))
      return 0;
    if (rule_dst[s] != 0 && (w.dest_address & rule_dmask[s]) != (rule_dst[s] & rule_dmask[s]))
      return 0;
    if (rule_sport[s] != 0 || rule_dport[s] != 0) begin
      if (!l4) return 0;
      if (rule_sport[s] != 0 && rule_sport[s] != w.source_port) return 0;
      if (rule_dport[s] != 0 && rule_dport[s] != w.dest_port) return 0;
    end
    return 1;
  endfunction

  task automatic classify_word(word_t w);
    outcome_t o;
    int hit, free_slot;
    bit inbound;
    o = '0;
    hit = -1;
    free_slot = -1;
    case (w.action)
      ACT_CHECK: begin
        inbound = (w.direction == 2'd0);
        stats[inbound ? STAT_TOTAL_IN : STAT_TOTAL_OUT]++;
        for (int i = 0; i < RULE_SLOTS; i++)
          if (hit < 0 && rule_valid[i] && slot_accepts(i, w)) hit = i;
        if (hit >= 0) begin
          hit_count[hit]++;
          o.verdict = fold_verdict(rule_verdict[hit]);
          o.matched = 1;
          o.rule_index = 4'(hit);
        end else begin
          o.verdict = fold_verdict(inbound ? dflt_in : dflt_out);
        end
        if (o.verdict == VERDICT_ACCEPT) stats[inbound ? STAT_ACC_IN : STAT_ACC_OUT]++;
        else if (o.verdict == VERDICT_DROP) stats[inbound ? STAT_DROP_IN : STAT_DROP_OUT]++;
        else stats[STAT_REJECT]++;
      end
      ACT_ADD: begin
        for (int i = 0; i < RULE_SLOTS; i++)
          if (free_slot < 0 && !rule_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          o.status = 1;
        end else begin
          rule_valid[free_slot] = 1;
          rule_dir[free_slot] = w.direction;
          rule_class[free_slot] = w.rule_protocol;
          rule_verdict[free_slot] = w.verdict_in;
          rule_src[free_slot] = w.source_address;
          rule_dst[free_slot] = w.dest_address;
          rule_smask[free_slot] = w.source_mask;
          rule_dmask[free_slot] = w.dest_mask;
          rule_sport[free_slot] = w.source_port;
          rule_dport[free_slot] = w.dest_port;
          hit_count[free_slot] = 0;
          o.rule_index = 4'(free_slot);
        end
      end
      ACT_REMOVE: begin
        if (!rule_valid[w.slot]) o.status = 1;
        else rule_valid[w.slot] = 0;
      end
      ACT_FLUSH: begin
        for (int i = 0; i < RULE_SLOTS; i++) begin
          rule_valid[i] = 0;
          hit_count[i] = 0;
        end
      end
      ACT_READ_COUNT: begin
        o.count_value = hit_count[w.slot];
        o.status = !rule_valid[w.slot];
      end
      ACT_READ_STAT: begin
        if (w.slot >= STAT_COUNT) o.status = 1;
        else o.count_value = stats[w.slot];
      end
      default: o.status = 1;
    endcase
    expected_outcomes.push_back(o);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: hold the word while busy, then move on to the next one
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) classify_word(drv);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
      end else if (pending_words.size() > 0) begin
        drv <= pending_words.pop_front();
        start <= 1;
        gap_left <= pick_gap();
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        report("unexpected result", count_value, 0);
      end else begin
        e = expected_outcomes.pop_front();
        if (verdict !== e.verdict) report("verdict", verdict, e.verdict);
        if (matched !== e.matched) report("matched", matched, e.matched);
        if (rule_index !== e.rule_index) report("rule_index", rule_index, e.rule_index);
        if (status !== e.status) report("status", status, e.status);
        if (count_value !== e.count_value) report("count_value", count_value, e.count_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("first_match_packet_filter regression: fail");
      $finish;
    end
  end

  function automatic word_t blank_word(logic [2:0] act);
    word_t w;
    w = '0;
    w.action = act;
    return w;
  endfunction

  function automatic word_t rule_word(logic [1:0] dir, logic [1:0] cls, logic [1:0] vd,
                                      logic [31:0] src, logic [31:0] smask,
                                      logic [31:0] dst, logic [31:0] dmask,
                                      logic [15:0] sp, logic [15:0] dp);
    word_t w;
    w = blank_word(ACT_ADD);
    w.direction = dir;
    w.rule_protocol = cls;
    w.verdict_in = vd;
    w.source_address = src;
    w.source_mask = smask;
    w.dest_address = dst;
    w.dest_mask = dmask;
    w.source_port = sp;
    w.dest_port = dp;
    return w;
  endfunction

  function automatic word_t packet_word(logic [1:0] dir, logic [7:0] proto,
                                        logic [31:0] src, logic [31:0] dst,
                                        logic [15:0] sp, logic [15:0] dp);
    word_t w;
    w = blank_word(ACT_CHECK);
    w.direction = dir;
    w.ip_protocol = proto;
    w.source_address = src;
    w.dest_address = dst;
    w.source_port = sp;
    w.dest_port = dp;
    return w;
  endfunction

  function automatic word_t slot_word(logic [2:0] act, logic [3:0] s);
    word_t w;
    w = blank_word(act);
    w.slot = s;
    return w;
  endfunction

  function automatic logic [31:0] some_address(bit for_rule);
    int r;
    r = $urandom_range(0, 9);
    if (for_rule && r < 3) return 0;
    if (r < 7) return addr_pool[$urandom_range(0, 3)] ^ (for_rule ? 0 : $urandom_range(0, 255));
    return $urandom;
  endfunction

  function automatic logic [31:0] some_mask();
    case ($urandom_range(0, 4))
      0: return 32'hffff_ffff;
      1: return 32'hffff_ff00;
      2: return 32'hffff_0000;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] some_port(bit for_rule);
    case ($urandom_range(0, 5))
      0: return for_rule ? 16'd0 : 16'd80;
      1: return for_rule ? 16'd0 : 16'd53;
      2: return 16'd80;
      3: return 16'd443;
      4: return 16'd53;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] some_protocol();
    case ($urandom_range(0, 4))
      0: return PROTO_ICMP;
      1: return PROTO_TCP;
      2: return PROTO_UDP;
      3: return PROTO_TCP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    int r;
    w = '0;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      w = packet_word(2'($urandom), some_protocol(), some_address(0), some_address(0),
                      some_port(0), some_port(0));
    end else if (r < 72) begin
      w = rule_word(2'($urandom), 2'($urandom), 2'($urandom), some_address(1), some_mask(),
                    some_address(1), some_mask(), some_port(1), some_port(1));
    end else if (r < 82) begin
      w = slot_word(ACT_REMOVE, 4'($urandom));
    end else if (r < 84) begin
      w = blank_word(ACT_FLUSH);
    end else if (r < 91) begin
      w = slot_word(ACT_READ_COUNT, 4'($urandom));
    end else if (r < 98) begin
      w = slot_word(ACT_READ_STAT, 4'($urandom_range(0, 8)));
    end else begin
      w = slot_word(3'($urandom_range(6, 7)), 4'($urandom));
    end
    // spare fields carry noise that the block must ignore
    if (w.action != ACT_ADD && $urandom_range(0, 3) == 0) begin
      w.source_mask = $urandom;
      w.dest_mask = $urandom;
      w.verdict_in = 2'($urandom);
      w.rule_protocol = 2'($urandom);
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [1:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= {30'($urandom), value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_DEF_IN) dflt_in = value;
    else dflt_out = value;
  endtask

  initial begin
    static logic [1:0] in_set [6] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0};
    static logic [1:0] out_set [6] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd1};
    rst = 1;
    start = 0;
    drv = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    dflt_in = 0;
    dflt_out = 0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      rule_valid[i] = 0;
      hit_count[i] = 0;
    end
    for (int i = 0; i < STAT_COUNT; i++) stats[i] = 0;
    for (int i = 0; i < 4; i++) addr_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 0;

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(ADDR_DEF_IN, in_set[phase]);
      write_reg(ADDR_DEF_OUT, out_set[phase]);
      no_gaps = (phase == 2);
      if (phase == 0) begin
        pending_words.push_back(rule_word(2'd0, RCLASS_TCP, VERDICT_DROP, addr_pool[0],
                                          32'hffff_ff00, 0, 0, 0, 16'd80));
        pending_words.push_back(rule_word(2'd1, RCLASS_UDP, 2'd3, 0, 0, addr_pool[1],
                                          32'hffff_ffff, 0, 16'd53));
        pending_words.push_back(rule_word(DIR_BOTH, RCLASS_ICMP, VERDICT_REJECT,
                                          0, 0, 0, 0, 0, 0));
        pending_words.push_back(rule_word(2'd0, 2'd0, VERDICT_ACCEPT, 0, 0, 0, 0,
                                          16'hffff, 0));
        pending_words.push_back(packet_word(2'd0, PROTO_TCP, addr_pool[0] ^ 32'h5, 32'h0,
                                            16'd1, 16'd80));
        pending_words.push_back(packet_word(2'd0, PROTO_TCP, addr_pool[0], 32'h1,
                                            16'd1, 16'd81));
        pending_words.push_back(packet_word(2'd1, PROTO_UDP, 0, addr_pool[1], 0, 16'd53));
        pending_words.push_back(packet_word(2'd3, PROTO_ICMP, '1, '1, '1, '1));
        pending_words.push_back(packet_word(2'd0, 8'hff, '1, '1, 16'hffff, 16'hffff));
        pending_words.push_back(packet_word(2'd0, PROTO_UDP, 0, 0, 16'hffff, 0));
        pending_words.push_back(packet_word(2'd2, 8'd0, 0, 0, 0, 0));
        pending_words.push_back(slot_word(ACT_READ_COUNT, 4'd0));
        pending_words.push_back(slot_word(ACT_READ_COUNT, 4'd3));
        pending_words.push_back(slot_word(ACT_READ_COUNT, 4'd15));
        pending_words.push_back(slot_word(ACT_REMOVE, 4'd3));
        pending_words.push_back(slot_word(ACT_REMOVE, 4'd3));
        pending_words.push_back(slot_word(ACT_READ_COUNT, 4'd3));
        pending_words.push_back(slot_word(ACT_REMOVE, 4'd15));
        for (int s = 0; s < 8; s++) pending_words.push_back(slot_word(ACT_READ_STAT, 4'(s)));
        pending_words.push_back(slot_word(ACT_READ_STAT, 4'd15));
        pending_words.push_back(slot_word(3'd6, 4'd0));
        pending_words.push_back(slot_word(3'd7, 4'd0));
        // fill the table, then two adds too many
        for (int i = 0; i < 14; i++)
          pending_words.push_back(rule_word(DIR_BOTH, RCLASS_TCP, i[1:0], $urandom,
                                            $urandom, $urandom, $urandom,
                                            16'($urandom), 0));
        pending_words.push_back(rule_word(2'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(blank_word(ACT_FLUSH));
        pending_words.push_back(slot_word(ACT_READ_COUNT, 4'd0));
      end else begin
        for (int i = 0; i < 170; i++) pending_words.push_back(random_word());
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (errors == 0)
      $display("first_match_packet_filter regression: pass");
    else
      $display("first_match_packet_filter regression: fail");
    $finish;
  end

endmodule
